// ----- rtl/ufs_pkg.sv -----
// shared types and constants for the url field splitter
`default_nettype none
package ufs_pkg;

  // default longest url in bytes
  localparam int UFS_MAX_LENGTH = 4096;

  // width of every offset and length field on the result side
  localparam int FIELD_W = 13;
  localparam int PORT_W  = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // byte classes
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_COLON = 3'd1;
  localparam logic [2:0] CLS_SLASH = 3'd2;
  localparam logic [2:0] CLS_QUEST = 3'd3;
  localparam logic [2:0] CLS_DIGIT = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // classified item as it travels from front to back
  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] digit;
    logic       last;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/ufs_front.sv -----
// front: classifies each incoming byte
`default_nettype none
module ufs_front
  import ufs_pkg::*;
(
  input  wire logic [7:0] char_byte,
  input  wire logic       last_byte,
  output item_t           item
);

  always_comb begin
    item.last  = last_byte;
    item.digit = 4'd0;
    if (char_byte == CH_COLON) begin
      item.cls = CLS_COLON;
    end else if (char_byte == CH_SLASH) begin
      item.cls = CLS_SLASH;
    end else if (char_byte == CH_QUEST) begin
      item.cls = CLS_QUEST;
    end else if (char_byte >= CH_ZERO && char_byte <= CH_NINE) begin
      item.cls   = CLS_DIGIT;
      item.digit = 4'(char_byte - CH_ZERO);
    end else begin
      item.cls = CLS_OTHER;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ufs_queue.sv -----
// short queue of classified items between front and back
`default_nettype none
module ufs_queue
  import ufs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire item_t wr_item,
  output logic       full,
  input  wire logic  rd_en,
  output item_t      rd_item,
  output logic       rd_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ufs_back.sv -----
// back: url parser state machine and result register
`default_nettype none
module ufs_back
  import ufs_pkg::*;
#(
  parameter int MAX_LENGTH = UFS_MAX_LENGTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire item_t              item,
  input  wire logic               item_valid,
  output logic                    item_take,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    has_scheme,
  output logic [FIELD_W-1:0]      scheme_length,
  output logic [FIELD_W-1:0]      host_offset,
  output logic [FIELD_W-1:0]      host_length,
  output logic [PORT_W-1:0]       port_number,
  output logic [FIELD_W-1:0]      path_offset,
  output logic [FIELD_W-1:0]      path_length,
  output logic                    has_params,
  output logic [FIELD_W-1:0]      param_offset,
  output logic [FIELD_W-1:0]      param_length,
  output logic                    too_long
);

  localparam int POS_W = $clog2(MAX_LENGTH + 1);
  localparam int HS_W  = POS_W + 1;
  localparam int OW    = FIELD_W;

  localparam logic [2:0] PH_SCAN = 3'd0;
  localparam logic [2:0] PH_SKIP = 3'd1;
  localparam logic [2:0] PH_HOST = 3'd2;
  localparam logic [2:0] PH_PORT = 3'd3;
  localparam logic [2:0] PH_PATH = 3'd4;

  logic [2:0]        phase,      phase_next;
  logic [POS_W-1:0]  pos,        pos_next;
  logic [OW-1:0]     scheme_len, scheme_len_next;
  logic [HS_W-1:0]   host_start, host_start_next;
  logic [OW-1:0]     host_len,   host_len_next;
  logic [PORT_W-1:0] port_acc,   port_acc_next;
  logic              port_done,  port_done_next;
  logic [OW-1:0]     path_start, path_start_next;
  logic [OW-1:0]     quest_pos,  quest_pos_next;
  logic              quest_seen, quest_seen_next;
  logic              ovf,        ovf_next;

  logic              out_valid;
  logic [19:0]       port_mul;

  logic              r_scheme;
  logic [OW-1:0]     r_scheme_len;
  logic [OW-1:0]     r_host_off;
  logic [OW-1:0]     r_host_len;
  logic [PORT_W-1:0] r_port;
  logic [OW-1:0]     r_path_off;
  logic [OW-1:0]     r_path_len;
  logic              r_params;
  logic [OW-1:0]     r_par_off;
  logic [OW-1:0]     r_par_len;
  logic              r_long;
  logic [OW-1:0]     len;

  // a last item needs the result slot, any other item always goes
  assign item_take = item_valid && (!item.last || !out_valid || pop);
  assign empty     = !out_valid;

  assign port_mul = {1'b0, port_acc, 3'b000} + {3'b000, port_acc, 1'b0} + 20'(item.digit);

  // parser step
  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    scheme_len_next = scheme_len;
    host_start_next = host_start;
    host_len_next   = host_len;
    port_acc_next   = port_acc;
    port_done_next  = port_done;
    path_start_next = path_start;
    quest_pos_next  = quest_pos;
    quest_seen_next = quest_seen;
    ovf_next        = ovf;
    if (item_take) begin
      if (pos >= POS_W'(MAX_LENGTH)) begin
        ovf_next = 1'b1;
      end else begin
        pos_next = pos + POS_W'(1);
        case (phase)
          PH_SCAN: begin
            if (item.cls == CLS_COLON) begin
              scheme_len_next = OW'(pos);
              host_start_next = HS_W'(pos) + HS_W'(3);
              quest_seen_next = 1'b0;
              quest_pos_next  = '0;
              phase_next      = PH_SKIP;
            end else if (item.cls == CLS_QUEST && !quest_seen) begin
              quest_pos_next  = OW'(pos);
              quest_seen_next = 1'b1;
            end
          end
          PH_SKIP: begin
            if (HS_W'(pos) + HS_W'(1) >= host_start) begin
              phase_next = PH_HOST;
            end
          end
          PH_HOST: begin
            if (item.cls == CLS_SLASH) begin
              host_len_next   = OW'(pos) - OW'(host_start);
              path_start_next = OW'(pos) + OW'(1);
              phase_next      = PH_PATH;
            end else if (item.cls == CLS_COLON) begin
              host_len_next  = OW'(pos) - OW'(host_start);
              port_acc_next  = '0;
              port_done_next = 1'b0;
              phase_next     = PH_PORT;
            end
          end
          PH_PORT: begin
            if (item.cls == CLS_SLASH) begin
              path_start_next = OW'(pos) + OW'(1);
              phase_next      = PH_PATH;
            end else if (!port_done && item.cls == CLS_DIGIT) begin
              // saturate at the top of the port range
              port_acc_next = (port_mul > 20'hFFFF) ? '1 : PORT_W'(port_mul);
            end else begin
              port_done_next = 1'b1;
            end
          end
          PH_PATH: begin
            if (item.cls == CLS_QUEST && !quest_seen) begin
              quest_pos_next  = OW'(pos);
              quest_seen_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // field layout from the state after the last byte
  always_comb begin
    len          = OW'(pos_next);
    r_scheme     = 1'b0;
    r_scheme_len = '0;
    r_host_off   = '0;
    r_host_len   = '0;
    r_port       = '0;
    r_path_off   = '0;
    r_path_len   = '0;
    r_params     = 1'b0;
    r_par_off    = '0;
    r_par_len    = '0;
    r_long       = 1'b0;
    if (ovf_next) begin
      r_long = 1'b1;
    end else begin
      if (phase_next == PH_SCAN || phase_next == PH_PATH) begin
        r_path_off = (phase_next == PH_PATH) ? path_start_next : '0;
        if (quest_seen_next) begin
          r_path_len = quest_pos_next - r_path_off;
          r_params   = 1'b1;
          r_par_off  = quest_pos_next + OW'(1);
          r_par_len  = len - r_par_off;
        end else begin
          r_path_len = len - r_path_off;
        end
      end else begin
        r_path_off = len;
      end
      if (phase_next != PH_SCAN) begin
        r_scheme     = 1'b1;
        r_scheme_len = scheme_len_next;
        r_port       = port_acc_next;
        if (phase_next == PH_SKIP) begin
          r_host_off = len;
        end else begin
          r_host_off = OW'(host_start_next);
          r_host_len = (phase_next == PH_HOST) ? len - OW'(host_start_next)
                                               : host_len_next;
        end
      end
    end
  end

  // parser registers, cleared at reset and after every url
  always_ff @(posedge clk) begin
    if (rst || (item_take && item.last)) begin
      phase      <= PH_SCAN;
      pos        <= '0;
      scheme_len <= '0;
      host_start <= '0;
      host_len   <= '0;
      port_acc   <= '0;
      port_done  <= 1'b0;
      path_start <= '0;
      quest_pos  <= '0;
      quest_seen <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      scheme_len <= scheme_len_next;
      host_start <= host_start_next;
      host_len   <= host_len_next;
      port_acc   <= port_acc_next;
      port_done  <= port_done_next;
      path_start <= path_start_next;
      quest_pos  <= quest_pos_next;
      quest_seen <= quest_seen_next;
      ovf        <= ovf_next;
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take && item.last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.last) begin
      has_scheme    <= r_scheme;
      scheme_length <= r_scheme_len;
      host_offset   <= r_host_off;
      host_length   <= r_host_len;
      port_number   <= r_port;
      path_offset   <= r_path_off;
      path_length   <= r_path_len;
      has_params    <= r_params;
      param_offset  <= r_par_off;
      param_length  <= r_par_len;
      too_long      <= r_long;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/url_field_splitter.sv -----
// top level of the url field splitter: front classifier, item queue, parser back
`default_nettype none
// a last byte is written into the queue, then taken by the back into the result slot register that drives the ports
// throughput: one byte per cycle while the back is not holding a last byte, set by the single-step parser in the back
// the back holds a last byte only while the result slot is full and not popped
// reset (rst, synchronous) empties the queue and result slot and restarts the parser
module url_field_splitter
  import ufs_pkg::*;
#(
  parameter int MAX_LENGTH = UFS_MAX_LENGTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // byte side
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         char_byte,
  input  wire logic               last_byte,
  // result side
  output logic                    empty,
  input  wire logic               pop,
  output logic                    has_scheme,
  output logic [FIELD_W-1:0]      scheme_length,
  output logic [FIELD_W-1:0]      host_offset,
  output logic [FIELD_W-1:0]      host_length,
  output logic [PORT_W-1:0]       port_number,
  output logic [FIELD_W-1:0]      path_offset,
  output logic [FIELD_W-1:0]      path_length,
  output logic                    has_params,
  output logic [FIELD_W-1:0]      param_offset,
  output logic [FIELD_W-1:0]      param_length,
  output logic                    too_long
);

  // classified item from the front
  item_t front_item;
  // item at the head of the queue
  item_t head_item;
  logic  head_valid;
  logic  head_take;

  // front: byte class compare, no state
  ufs_front u_front (
    .char_byte (char_byte),
    .last_byte (last_byte),
    .item      (front_item)
  );

  // queue lets the byte side keep pushing while the back waits on pop
  ufs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_item  (front_item),
    .full     (full),
    .rd_en    (head_take),
    .rd_item  (head_item),
    .rd_valid (head_valid)
  );

  // back: parser phases, position counter, field registers and result slot
  ufs_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (head_item),
    .item_valid    (head_valid),
    .item_take     (head_take),
    .empty         (empty),
    .pop           (pop),
    .has_scheme    (has_scheme),
    .scheme_length (scheme_length),
    .host_offset   (host_offset),
    .host_length   (host_length),
    .port_number   (port_number),
    .path_offset   (path_offset),
    .path_length   (path_length),
    .has_params    (has_params),
    .param_offset  (param_offset),
    .param_length  (param_length),
    .too_long      (too_long)
  );

endmodule
`default_nettype wire

// ----- sim/url_field_splitter_test.sv -----
// self-checking testbench for the url field splitter: directed table, then random urls
`default_nettype none
module url_field_splitter_test
  import ufs_pkg::*;
();

  // cycles with no item moving on either side before the run is called hung
  localparam int STALL_LIMIT = 4000;
  // random part stops once this many bytes of random urls have gone in
  localparam int BYTE_TARGET = 1500;
  // extra wait at the end for any stray result to show up
  localparam int TAIL_CYCLES = 8;

  // one parsed url as it leaves the block
  typedef struct packed {
    logic               has_scheme;
    logic [FIELD_W-1:0] scheme_length;
    logic [FIELD_W-1:0] host_offset;
    logic [FIELD_W-1:0] host_length;
    logic [PORT_W-1:0]  port_number;
    logic [FIELD_W-1:0] path_offset;
    logic [FIELD_W-1:0] path_length;
    logic               has_params;
    logic [FIELD_W-1:0] param_offset;
    logic [FIELD_W-1:0] param_length;
    logic               too_long;
  } url_fields_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic [7:0]  ch;
    logic        is_last;
    logic        typed;
    url_fields_t want;
  } dir_row_t;

  // where the splitter is inside the current url
  typedef enum logic [2:0] {
    SCAN_SCHEME, SKIP_SEP, HOST_TEXT, PORT_DIGITS, PATH_TEXT
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [7:0] char_byte = 8'h00;
  logic last_byte = 1'b0;
  logic full, empty;
  logic has_scheme, has_params, too_long;
  logic [FIELD_W-1:0] scheme_length, host_offset, host_length;
  logic [FIELD_W-1:0] path_offset, path_length, param_offset, param_length;
  logic [PORT_W-1:0] port_number;

  url_field_splitter dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .char_byte(char_byte), .last_byte(last_byte),
    .empty(empty), .pop(pop),
    .has_scheme(has_scheme), .scheme_length(scheme_length),
    .host_offset(host_offset), .host_length(host_length),
    .port_number(port_number), .path_offset(path_offset),
    .path_length(path_length), .has_params(has_params),
    .param_offset(param_offset), .param_length(param_length),
    .too_long(too_long)
  );

  always #5 clk = ~clk;

  // parsed urls still owed by the block, oldest first
  url_fields_t expected_urls[$];
  int errors = 0;
  // no idling on either side while set
  bit steady = 1'b0;
  // bytes of the url being built before it is sent
  logic [7:0] url_bytes[$];

  // ---------------------------------------------------------------
  // url splitter predictor: its own copy of the parse state
  // ---------------------------------------------------------------
  parse_phase_t phase;
  int unsigned pos, scheme_len, host_start, host_len, port_val, path_start, quest_pos;
  bit port_done, quest_seen, overflowed;

  function automatic void clear_parser();
    phase = SCAN_SCHEME;
    pos = 0;
    scheme_len = 0;
    host_start = 0;
    host_len = 0;
    port_val = 0;
    port_done = 1'b0;
    path_start = 0;
    quest_pos = 0;
    quest_seen = 1'b0;
    overflowed = 1'b0;
  endfunction

  // take one byte; on the last byte hand back the field layout and restart
  function automatic void split_byte(input logic [7:0] ch, input logic is_last,
                                     output bit done, output url_fields_t res);
    int unsigned p, len, poff, plen, qoff, qlen, v, hoff, hlen;
    bit params;
    done = 1'b0;
    res = '0;
    if (pos >= UFS_MAX_LENGTH) begin
      // bytes past the longest url are dropped
      overflowed = 1'b1;
    end else begin
      p = pos;
      case (phase)
        SCAN_SCHEME: begin
          if (ch == CH_COLON) begin
            scheme_len = p;
            host_start = p + 3;
            quest_seen = 1'b0;   // a question mark before the colon is forgotten
            quest_pos = 0;
            phase = SKIP_SEP;
          end else if (ch == CH_QUEST && !quest_seen) begin
            quest_pos = p;
            quest_seen = 1'b1;
          end
        end
        SKIP_SEP: begin
          if (p + 1 >= host_start) phase = HOST_TEXT;
        end
        HOST_TEXT: begin
          if (ch == CH_SLASH) begin
            host_len = p - host_start;
            path_start = p + 1;
            phase = PATH_TEXT;
          end else if (ch == CH_COLON) begin
            host_len = p - host_start;
            port_val = 0;
            port_done = 1'b0;
            phase = PORT_DIGITS;
          end
        end
        PORT_DIGITS: begin
          if (ch == CH_SLASH) begin
            path_start = p + 1;
            phase = PATH_TEXT;
          end else if (!port_done && ch >= CH_ZERO && ch <= CH_NINE) begin
            // decimal accumulate, pinned at the top of the port range
            v = port_val * 10 + (32'(ch) - 32'(CH_ZERO));
            port_val = (v > 65535) ? 65535 : v;
          end else begin
            port_done = 1'b1;
          end
        end
        default: begin
          if (ch == CH_QUEST && !quest_seen) begin
            quest_pos = p;
            quest_seen = 1'b1;
          end
        end
      endcase
      pos = p + 1;
    end
    if (is_last) begin
      done = 1'b1;
      len = pos;
      if (overflowed) begin
        res.too_long = 1'b1;
      end else begin
        poff = 0;
        plen = 0;
        params = 1'b0;
        qoff = 0;
        qlen = 0;
        if (phase == SCAN_SCHEME || phase == PATH_TEXT) begin
          poff = (phase == PATH_TEXT) ? path_start : 0;
          if (quest_seen) begin
            plen = quest_pos - poff;
            params = 1'b1;
            qoff = quest_pos + 1;
            qlen = len - qoff;
          end else begin
            plen = len - poff;
          end
        end else begin
          // url ended before any path
          poff = len;
        end
        if (phase != SCAN_SCHEME) begin
          res.has_scheme = 1'b1;
          res.scheme_length = scheme_len[FIELD_W-1:0];
          if (phase == SKIP_SEP) begin
            res.host_offset = len[FIELD_W-1:0];
          end else begin
            hoff = host_start;
            hlen = (phase == HOST_TEXT) ? len - host_start : host_len;
            res.host_offset = hoff[FIELD_W-1:0];
            res.host_length = hlen[FIELD_W-1:0];
            if (phase == PORT_DIGITS ||
                (phase == PATH_TEXT && path_start > 0 && port_val != 0))
              res.port_number = port_val[PORT_W-1:0];
          end
        end
        res.path_offset = poff[FIELD_W-1:0];
        res.path_length = plen[FIELD_W-1:0];
        res.has_params = params;
        res.param_offset = qoff[FIELD_W-1:0];
        res.param_length = qlen[FIELD_W-1:0];
      end
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------
  // byte side: drive one item and hold it until the block takes it
  // ---------------------------------------------------------------
  task automatic send_item(input logic [7:0] ch, input logic is_last, input bit hold_off,
                           input bit use_typed, input url_fields_t typed_want);
    bit done;
    url_fields_t res;
    int gap;
    char_byte <= ch;
    last_byte <= is_last;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    // item taken at this edge
    split_byte(ch, is_last, done, res);
    if (done) expected_urls.push_back(use_typed ? typed_want : res);
    // each idle cycle drawn on its own, so about a third of cycles idle
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 32) gap++;
    end
    if (hold_off) begin
      // stop sending until the block has handed back everything owed
      push <= 1'b0;
      @(posedge clk);
      while (expected_urls.size() != 0) @(posedge clk);
    end else if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send the built url; optionally pause after its last byte
  task automatic send_url(input bit hold_at_end);
    int n;
    n = url_bytes.size();
    for (int i = 0; i < n; i++)
      send_item(url_bytes[i], i == n - 1, hold_at_end && i == n - 1, 1'b0, '0);
  endtask

  // ordinary text byte, never one of the separators
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_COLON || b == CH_SLASH || b == CH_QUEST);
    return b;
  endfunction

  // any byte, leaning on separators and digits
  function automatic logic [7:0] any_byte();
    case ($urandom_range(7))
      0: return CH_COLON;
      1: return CH_SLASH;
      2: return CH_QUEST;
      3: return CH_ZERO + 8'($urandom_range(9));
      default: return 8'($urandom);
    endcase
  endfunction

  // mode 0: well formed url, 1: well formed but cut short, 2: noise
  task automatic build_url(input int mode);
    int n, keep;
    url_bytes.delete();
    if (mode == 2) begin
      n = $urandom_range(1, 20);
      repeat (n) url_bytes.push_back(any_byte());
    end else begin
      // scheme, colon and the two separator bytes
      repeat ($urandom_range(0, 5)) url_bytes.push_back(plain_byte());
      url_bytes.push_back(CH_COLON);
      repeat (2) url_bytes.push_back($urandom_range(3) != 0 ? CH_SLASH : any_byte());
      // host, sometimes with a stray question mark
      repeat ($urandom_range(0, 8))
        url_bytes.push_back($urandom_range(15) == 0 ? CH_QUEST : plain_byte());
      // port: digits, sometimes junk in between
      if ($urandom_range(1) == 1) begin
        url_bytes.push_back(CH_COLON);
        repeat ($urandom_range(0, 7))
          url_bytes.push_back($urandom_range(4) == 0 ? plain_byte()
                                                      : CH_ZERO + 8'($urandom_range(9)));
      end
      // path
      if ($urandom_range(3) != 0) begin
        url_bytes.push_back(CH_SLASH);
        repeat ($urandom_range(0, 8))
          url_bytes.push_back($urandom_range(5) == 0 ? any_byte() : plain_byte());
      end
      // parameters
      if ($urandom_range(1) == 1) begin
        url_bytes.push_back(CH_QUEST);
        repeat ($urandom_range(0, 6)) url_bytes.push_back(any_byte());
      end
      if (mode == 1) begin
        keep = $urandom_range(1, url_bytes.size());
        while (url_bytes.size() > keep) void'(url_bytes.pop_back());
      end
    end
  endtask

  // ---------------------------------------------------------------
  // result side: random pop, compare each result with the oldest owed
  // ---------------------------------------------------------------
  always @(posedge clk) pop <= steady || ($urandom_range(99) >= 32);

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    url_fields_t want;
    if (!rst && pop && !empty) begin
      if (expected_urls.size() == 0) begin
        $display("%0t: result with nothing expected, expected none got path_length %0d",
                 $time, path_length);
        errors++;
      end else begin
        want = expected_urls.pop_front();
        check_field("has_scheme", want.has_scheme, has_scheme);
        check_field("scheme_length", want.scheme_length, scheme_length);
        check_field("host_offset", want.host_offset, host_offset);
        check_field("host_length", want.host_length, host_length);
        check_field("port_number", want.port_number, port_number);
        check_field("path_offset", want.path_offset, path_offset);
        check_field("path_length", want.path_length, path_length);
        check_field("has_params", want.has_params, has_params);
        check_field("param_offset", want.param_offset, param_offset);
        check_field("param_length", want.param_length, param_length);
        check_field("too_long", want.too_long, too_long);
      end
    end
  end

  // watchdog on cycles where nothing moves on either side
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // directed table: edge bytes, every separator, each corner of the parse
  // ---------------------------------------------------------------
  localparam int DIR_ROWS = 21;
  dir_row_t directed_rows [DIR_ROWS] = '{
    // single zero byte and single all-ones byte: whole url is path
    '{8'h00, 1'b1, 1'b1, '{path_length: 13'd1, default: '0}},
    '{8'hFF, 1'b1, 1'b1, '{path_length: 13'd1, default: '0}},
    // lone colon: ends before the host starts
    '{CH_COLON, 1'b1, 1'b1,
      '{has_scheme: 1'b1, host_offset: 13'd1, path_offset: 13'd1, default: '0}},
    // lone question mark: empty path, empty parameters
    '{CH_QUEST, 1'b1, 1'b1,
      '{has_params: 1'b1, param_offset: 13'd1, default: '0}},
    // full url with a port that saturates
    '{"h", 1'b0, 1'b0, '0},
    '{CH_COLON, 1'b0, 1'b0, '0},
    '{"x", 1'b0, 1'b0, '0},
    '{CH_SLASH, 1'b0, 1'b0, '0},
    '{"a", 1'b0, 1'b0, '0},
    '{CH_COLON, 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{CH_SLASH, 1'b0, 1'b0, '0},
    '{"p", 1'b0, 1'b0, '0},
    '{CH_QUEST, 1'b0, 1'b0, '0},
    '{"q", 1'b1, 1'b0, '0},
    // question mark before the colon is forgotten
    '{CH_QUEST, 1'b0, 1'b0, '0},
    '{CH_COLON, 1'b1, 1'b0, '0}
  };

  initial begin : run
    int bytes_sent, url_count, r;
    bit last_url;
    clear_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part, then wait for every result before going random
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(directed_rows[i].ch, directed_rows[i].is_last, i == DIR_ROWS - 1,
                directed_rows[i].typed, directed_rows[i].want);

    // random part: mostly well formed urls, some cut short, some noise
    bytes_sent = 0;
    url_count = 0;
    while (bytes_sent < BYTE_TARGET) begin
      steady = (url_count >= 20 && url_count < 36);
      r = $urandom_range(99);
      build_url(r < 70 ? 0 : (r < 85 ? 1 : 2));
      last_url = (bytes_sent + url_bytes.size() >= BYTE_TARGET);
      send_url(last_url);
      bytes_sent += url_bytes.size();
      url_count++;
    end

    // everything owed has arrived; let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_urls.size() != 0)
      $display("%0t: %0d results never arrived", $time, expected_urls.size());
    if (errors == 0 && expected_urls.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/ufs_pkg.sv
rtl/ufs_front.sv
rtl/ufs_queue.sv
rtl/ufs_back.sv
rtl/url_field_splitter.sv
sim/url_field_splitter_test.sv
